>>> rtl/core/button_debounce_press_classifier_assert.svh
// Assertion macros used by the button debounce classifier RTL.
// Needs clk and rst in scope where a macro is used.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bdpc_pkg.sv
// Shared types and constants for the button debounce classifier.
// No dependencies; compile first after the assertion header.
package bdpc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_BITS      = 32;
  localparam int LEVEL_BITS    = 3;
  localparam int NUM_BUTTONS   = 3;
  localparam int EVENT_BITS    = 3;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_US_RESET   = CFG_BITS'(30 * 1000);
  localparam logic [CFG_BITS-1:0] LONG_PRESS_US_RESET = CFG_BITS'(1000 * 1000);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 1'd1;

  // Event codes
  localparam logic [EVENT_BITS-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_BITS-1:0] EV_B0_LONG  = 3'd1;
  localparam logic [EVENT_BITS-1:0] EV_B0_PRESS = 3'd2;
  localparam logic [EVENT_BITS-1:0] EV_B1_PRESS = 3'd3;
  localparam logic [EVENT_BITS-1:0] EV_B2_PRESS = 3'd4;

  // Release classification of one button for the current poll
  typedef struct packed {
    logic short_rel;  // release longer than debounce, not long
    logic long_rel;   // release longer than the long-press time
  } lane_evt_t;

endpackage

>>> rtl/core/bdpc_if.sv
// Poll and result channel interfaces for the button debounce classifier.
// Depends on bdpc_pkg for field widths.
interface bdpc_in_if import bdpc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] raw_levels;
  logic [CFG_BITS-1:0]   now_us;

  modport source (output valid, output raw_levels, output now_us, input ready);
  modport sink   (input valid, input raw_levels, input now_us, output ready);
endinterface

interface bdpc_out_if import bdpc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [EVENT_BITS-1:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink   (input valid, input event_res, output ready);
endinterface

>>> rtl/core/bdpc_lane.sv
// One button: raw level tracking, debounce and press timing.
// Depends on bdpc_pkg; instantiated by button_debounce_press_classifier.
module bdpc_lane import bdpc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 commit,
  input  logic                 level,
  input  logic [TIME_BITS-1:0] now,
  input  logic [CFG_BITS-1:0]  debounce_us,
  input  logic [CFG_BITS-1:0]  long_press_us,
  output lane_evt_t            evt
);

  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  logic                 raw_seen;
  logic                 stable_level;
  logic [TIME_BITS-1:0] change_time;
  logic [TIME_BITS-1:0] press_begin;

  logic                 raw;
  logic [TIME_BITS-1:0] change_time_next;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] dur;
  logic                 settle;
  logic                 release_now;
  logic                 dur_long;
  logic                 dur_short;

  always_comb begin
    raw              = ~level;
    change_time_next = (raw != raw_seen) ? now : change_time;
    held             = now - change_time_next;
    dur              = now - press_begin;
    settle           = (CMP_BITS'(held) > CMP_BITS'(debounce_us)) && (raw != stable_level);
    release_now      = settle && !raw;
    dur_long         = CMP_BITS'(dur) > CMP_BITS'(long_press_us);
    dur_short        = CMP_BITS'(dur) > CMP_BITS'(debounce_us);
    evt.long_rel     = release_now && dur_long;
    evt.short_rel    = release_now && !dur_long && dur_short;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_seen     <= 1'b0;
      stable_level <= 1'b0;
      change_time  <= '0;
      press_begin  <= '0;
    end else if (commit) begin
      raw_seen    <= raw;
      change_time <= change_time_next;
      if (settle) begin
        stable_level <= raw;
        if (raw) begin
          press_begin <= now;
        end
      end
    end
  end

endmodule

>>> rtl/core/button_debounce_press_classifier.sv
// A poll passes the input register, then the result register, before its result is offered;
// a stalled result holds it back in those registers.
// Throughput: one poll per cycle while results are taken; all three button lanes evaluate in parallel.
// A stalled result holds while one further poll waits in the input register.
// Reset (rst, synchronous, active high): button state cleared to not pressed, times to zero,
// debounce_us to 30000 and long_press_us to 1000000; both channel stages emptied.
module button_debounce_press_classifier import bdpc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  bdpc_in_if.sink                 poll,
  bdpc_out_if.source              result,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

`include "button_debounce_press_classifier_assert.svh"

  // Configuration registers
  logic [CFG_BITS-1:0] debounce_us;
  logic [CFG_BITS-1:0] long_press_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us   <= DEBOUNCE_US_RESET;
      long_press_us <= LONG_PRESS_US_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_us   <= cfg_data;
        REG_LONG_PRESS: long_press_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: holds one poll until the result register can take its event.
  logic                  s1_valid;
  logic [LEVEL_BITS-1:0] s1_levels;
  logic [CFG_BITS-1:0]   s1_now;

  logic                  res_valid;
  logic [EVENT_BITS-1:0] res_event;
  logic                  advance;

  // Result register frees up when empty or when its transfer completes this cycle.
  assign advance    = !res_valid || result.ready;
  assign poll.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_levels <= poll.raw_levels;
      s1_now    <= poll.now_us;
    end
  end

  // Button lanes. Times are kept modulo 2^TIME_BITS, so cut or widen the stamp first.
  logic [TIME_BITS-1:0]   now_t;
  logic [NUM_BUTTONS-1:0] commit;
  lane_evt_t              evt [NUM_BUTTONS];
  logic                   hit0;
  logic                   hit1;
  logic                   step;

  assign now_t = TIME_BITS'(s1_now);
  assign step  = s1_valid && advance;

  // The first event ends the poll: a lane commits only when no earlier lane fired.
  // A long release on button 1 or 2 gives no event and lets the poll go on.
  assign hit0      = evt[0].short_rel || evt[0].long_rel;
  assign hit1      = evt[1].short_rel;
  assign commit[0] = step;
  assign commit[1] = step && !hit0;
  assign commit[2] = step && !hit0 && !hit1;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bdpc_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk           (clk),
      .rst           (rst),
      .commit        (commit[g]),
      .level         (s1_levels[g]),
      .now           (now_t),
      .debounce_us   (debounce_us),
      .long_press_us (long_press_us),
      .evt           (evt[g])
    );
  end

  // Pick the event code with button 0 first.
  logic [EVENT_BITS-1:0] event_next;

  always_comb begin
    if (evt[0].long_rel) begin
      event_next = EV_B0_LONG;
    end else if (evt[0].short_rel) begin
      event_next = EV_B0_PRESS;
    end else if (evt[1].short_rel) begin
      event_next = EV_B1_PRESS;
    end else if (evt[2].short_rel) begin
      event_next = EV_B2_PRESS;
    end else begin
      event_next = EV_NONE;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_event <= event_next;
    end
  end

  assign result.valid     = res_valid;
  assign result.event_res = res_event;

  `BDPC_ASSERT_NOW(a_ready_when_empty, !res_valid, poll.ready, "poll blocked with empty result")
  `BDPC_ASSERT_NEXT(a_s1_hold, s1_valid && !advance, s1_valid, "waiting poll dropped")
  `BDPC_ASSERT_NOW(a_lane_gate, commit[2], commit[1] && !hit1, "lane 2 updated after an event")
  `BDPC_ASSERT_NEXT(a_code_range, step, res_event <= EV_B2_PRESS, "event code out of range")

endmodule
